[src/rgbhsv_pkg.sv]
// shared types and constants for the rgb to hsv pixel converter
// no dependencies
package rgbhsv_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned HUE_W   = 9;
	localparam int unsigned NUMER_W = 17;
	localparam int unsigned REM_W   = CH_W + 1;

	localparam logic [5:0]       HUE_SCALE  = 6'd60;
	localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;
	localparam logic [HUE_W-1:0] OFS_RED    = 9'd360;
	localparam logic [HUE_W-1:0] OFS_GREEN  = 9'd120;
	localparam logic [HUE_W-1:0] OFS_BLUE   = 9'd240;
	localparam logic [CH_W-1:0]  CH_FULL    = 8'd255;

	// per-pixel data that rides alongside the divider lanes
	typedef struct packed {
		logic [CH_W-1:0] value;
		logic            last;
		logic            hue_zero;
		logic            sat_zero;
	} side_t;

	// front stage result handed to the first divider cell
	typedef struct packed {
		logic [REM_W-1:0] hue_rem;
		logic [CH_W-1:0]  hue_low;
		logic [CH_W-1:0]  delta;
		side_t            side;
	} front_t;

endpackage

[src/rgbhsv_front.sv]
// front stage: max, min, spread and hue numerator, registered
// depends on rgbhsv_pkg
module rgbhsv_front (
	input  logic                    clk,
	input  logic                    en,
	input  logic [7:0]              red,
	input  logic [7:0]              green,
	input  logic [7:0]              blue,
	input  logic                    last_in,
	output rgbhsv_pkg::front_t      front_s1
);
	import rgbhsv_pkg::*;

	logic              red_max;
	logic              green_max;
	logic [CH_W-1:0]   cmax;
	logic [CH_W-1:0]   cmin;
	logic [CH_W-1:0]   delta;
	logic signed [CH_W:0] diff;
	logic [HUE_W-1:0]  ofs;
	logic [NUMER_W-1:0] ofs_term;
	logic signed [18:0] numer;
	front_t            nxt;

	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max) begin
			cmax = red;
			diff = $signed({1'b0, green}) - $signed({1'b0, blue});
			ofs  = OFS_RED;
		end else if (green_max) begin
			cmax = green;
			diff = $signed({1'b0, blue}) - $signed({1'b0, red});
			ofs  = OFS_GREEN;
		end else begin
			cmax = blue;
			diff = $signed({1'b0, red}) - $signed({1'b0, green});
			ofs  = OFS_BLUE;
		end
		cmin = red;
		if (green < cmin) cmin = green;
		if (blue < cmin) cmin = blue;
		delta    = cmax - cmin;
		// full width product, at most 360 * 255
		ofs_term = NUMER_W'(ofs) * NUMER_W'(delta);
		// |diff| <= delta so this stays positive
		numer = (19'(diff) * $signed({13'd0, HUE_SCALE})) + $signed({2'b00, ofs_term});

		nxt.hue_rem       = numer[16:8];
		nxt.hue_low       = numer[7:0];
		nxt.delta         = delta;
		nxt.side.value    = cmax;
		nxt.side.last     = last_in;
		nxt.side.hue_zero = (delta == '0);
		nxt.side.sat_zero = (cmax == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_s1 <= nxt;
		end
	end

endmodule

[src/rgbhsv_div_cell.sv]
// one restoring division step: a quotient bit per cell, registered
// depends on rgbhsv_pkg
module rgbhsv_div_cell #(
	parameter int unsigned FRAC = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rgbhsv_pkg::REM_W-1:0]  rem_i,
	input  logic [FRAC-1:0]               dvd_i,
	input  logic [FRAC:0]                 quo_i,
	input  logic [rgbhsv_pkg::CH_W-1:0]   div_i,
	output logic [rgbhsv_pkg::REM_W-1:0]  rem_q,
	output logic [FRAC-1:0]               dvd_q,
	output logic [FRAC:0]                 quo_q,
	output logic [rgbhsv_pkg::CH_W-1:0]   div_q
);
	import rgbhsv_pkg::*;

	logic             ge;
	logic [REM_W-1:0] diff;

	always_comb begin
		ge   = rem_i >= {1'b0, div_i};
		diff = ge ? (rem_i - {1'b0, div_i}) : rem_i;
	end

	// remainder below divisor after the step, so the low bits hold it
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= {diff[CH_W-1:0], dvd_i[FRAC-1]};
			dvd_q <= {dvd_i[FRAC-2:0], 1'b0};
			quo_q <= {quo_i[FRAC-1:0], ge};
			div_q <= div_i;
		end
	end

endmodule

[src/rgb_to_hsv_pixel.sv]
// rgb to hsv pixel converter, top level
// depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_div_cell
// from input beat to output beat: front register, then the divider cells, then the output register
// throughput: one pixel per cycle unless stalled, set by a chain of SAT_FRAC_BITS + 1 divider cells
//   per lane, each producing one quotient bit; the whole chain stalls together
// reset: arst_n clears the stage valid bits only; data registers are not reset
module rgb_to_hsv_pixel #(
	parameter int unsigned SAT_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // red, green, blue
	input  logic                 s_tlast,   // last_in
	// master side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [((SAT_FRAC_BITS + 18 + 7) / 8) * 8 - 1:0] m_tdata, // hue, saturation, value, pad
	output logic                 m_tlast    // last_out
);
	import rgbhsv_pkg::*;

	localparam int unsigned F     = SAT_FRAC_BITS;
	localparam int unsigned NCELL = F + 1;
	localparam int unsigned OUT_W = ((F + 18 + 7) / 8) * 8;
	localparam int unsigned PAY_W = F + 18;

	// one stall enable for the whole chain
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	front_t front_s1;

	rgbhsv_front u_front (
		.clk      (clk),
		.en       (en),
		.red      (s_tdata[7:0]),
		.green    (s_tdata[15:8]),
		.blue     (s_tdata[23:16]),
		.last_in  (s_tlast),
		.front_s1 (front_s1)
	);

	// valid bit per stage: front, then one per cell
	logic [NCELL:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NCELL-1:0], s_tvalid};
		end
	end

	// hue lane: dividend is the numerator scaled by 2^(F-8)
	logic [REM_W-1:0] h_rem [NCELL+1];
	logic [F-1:0]     h_dvd [NCELL+1];
	logic [F:0]       h_quo [NCELL+1];
	logic [CH_W-1:0]  h_div [NCELL+1];
	// saturation lane: dividend is the spread scaled by 2^F
	logic [REM_W-1:0] s_rem [NCELL+1];
	logic [F-1:0]     s_dvd [NCELL+1];
	logic [F:0]       s_quo [NCELL+1];
	logic [CH_W-1:0]  s_div [NCELL+1];
	side_t            side  [NCELL+1];

	assign h_rem[0] = front_s1.hue_rem;
	assign h_dvd[0] = F'(front_s1.hue_low) << (F - 8);
	assign h_quo[0] = '0;
	assign h_div[0] = front_s1.delta;
	assign s_rem[0] = {1'b0, front_s1.delta};
	assign s_dvd[0] = '0;
	assign s_quo[0] = '0;
	assign s_div[0] = front_s1.side.value;
	assign side[0]  = front_s1.side;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		rgbhsv_div_cell #(.FRAC(F)) u_hue (
			.clk   (clk),
			.en    (en),
			.rem_i (h_rem[k]),
			.dvd_i (h_dvd[k]),
			.quo_i (h_quo[k]),
			.div_i (h_div[k]),
			.rem_q (h_rem[k+1]),
			.dvd_q (h_dvd[k+1]),
			.quo_q (h_quo[k+1]),
			.div_q (h_div[k+1])
		);
		rgbhsv_div_cell #(.FRAC(F)) u_sat (
			.clk   (clk),
			.en    (en),
			.rem_i (s_rem[k]),
			.dvd_i (s_dvd[k]),
			.quo_i (s_quo[k]),
			.div_i (s_div[k]),
			.rem_q (s_rem[k+1]),
			.dvd_q (s_dvd[k+1]),
			.quo_q (s_quo[k+1]),
			.div_q (s_div[k+1])
		);
		// sideband follows the pixel through the chain
		always_ff @(posedge clk) begin
			if (en) begin
				side[k+1] <= side[k];
			end
		end
	end

	// back end: drop the extra hue fraction bits, wrap at 360, apply zero cases
	logic [HUE_W-1:0] hue_raw;
	logic [HUE_W-1:0] hue_fin;
	logic [F:0]       sat_fin;
	side_t            side_end;

	always_comb begin
		side_end = side[NCELL];
		hue_raw  = h_quo[NCELL][F:F-8];
		hue_fin  = (hue_raw >= HUE_WRAP) ? (hue_raw - HUE_WRAP) : hue_raw;
		if (side_end.hue_zero) hue_fin = '0;
		sat_fin  = side_end.sat_zero ? '0 : s_quo[NCELL];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_q[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OUT_W'({side_end.value, sat_fin, hue_fin});
			m_tlast <= side_end.last;
		end
	end

`ifndef SYNTHESIS
	// hue always wrapped into range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[HUE_W-1:0] < HUE_WRAP))
		else $error("hue out of range");

	// saturation never above one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[HUE_W+F:HUE_W] <= ((F+1)'(1) << F)))
		else $error("saturation above one");

	// black pixel gives zero saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[PAY_W-1:PAY_W-8] == '0)) |-> (m_tdata[HUE_W+F:HUE_W] == '0))
		else $error("nonzero saturation on black");

	// a stalled output freezes the whole chain
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(vld_q))
		else $error("chain moved during stall");
`endif

endmodule

[verif/tb_rgb_to_hsv_pixel.sv]
// testbench for rgb_to_hsv_pixel: drives rgb pixel beats, predicts hue/saturation/value
// depends on rgbhsv_pkg and the rgb_to_hsv_pixel rtl
module tb_rgb_to_hsv_pixel;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbhsv_pkg::*;

	localparam int unsigned SAT_FRAC_BITS = 16;
	localparam int unsigned SAT_W = SAT_FRAC_BITS + 1;
	localparam int unsigned OUT_W = ((SAT_FRAC_BITS + 18 + 7) / 8) * 8;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		logic [CH_W-1:0]  value;
		logic             last;
	} hsv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;

	hsv_t hsv_expected[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	rgb_to_hsv_pixel #(.SAT_FRAC_BITS(SAT_FRAC_BITS)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exact integer hsv of one pixel
	function automatic hsv_t rgb_to_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic last);
		hsv_t h;
		int cmax, cmin, spread, diff, ofs;
		cmax = r;
		if (g > cmax) cmax = g;
		if (b > cmax) cmax = b;
		cmin = r;
		if (g < cmin) cmin = g;
		if (b < cmin) cmin = b;
		spread = cmax - cmin;
		h = '0;
		h.value = cmax[7:0];
		h.last = last;
		if (spread != 0) begin
			// red wins ties, then green
			if (cmax == r) begin
				diff = int'(g) - int'(b);
				ofs = 360;
			end else if (cmax == g) begin
				diff = int'(b) - int'(r);
				ofs = 120;
			end else begin
				diff = int'(r) - int'(g);
				ofs = 240;
			end
			h.hue = HUE_W'(((60 * diff + ofs * spread) / spread) % 360);
		end
		if (cmax != 0)
			h.sat = SAT_W'((longint'(spread) << SAT_FRAC_BITS) / cmax);
		return h;
	endfunction

	// one pixel beat; inputs change at the falling edge, valid stays up for the next beat
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hsv_expected.push_back(rgb_to_hsv(r, g, b, last));
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk)
		m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		hsv_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.hue = m_tdata[HUE_W-1:0];
			got.sat = m_tdata[HUE_W +: SAT_W];
			got.value = m_tdata[HUE_W+SAT_W +: CH_W];
			got.last = m_tlast;
			if (hsv_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat: %p", got);
			end else begin
				want = hsv_expected.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	task automatic test_corners();
		logic [7:0] corner[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);          // black
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);    // white, zero spread
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd0, 1'b0);      // red and green tie
		send_pixel(8'd0, 8'd255, 8'd255, 1'b0);      // green and blue tie
		send_pixel(8'd255, 8'd0, 8'd255, 1'b0);      // red and blue tie
		send_pixel(8'd255, 8'd0, 8'd1, 1'b0);        // hue wraps near 360
		send_pixel(8'd1, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		for (int i = 0; i < 12; i++)
			send_pixel(corner[2'($urandom_range(3))], corner[2'($urandom_range(3))],
				corner[2'($urandom_range(3))], 1'($urandom_range(1)));
	endtask

	task automatic test_random(int count);
		logic [7:0] r, g, b;
		for (int i = 0; i < count; i++) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			// some near-gray pixels for small spreads
			if ($urandom_range(3) == 0) begin
				g = r + 8'($urandom_range(2));
				b = r - 8'($urandom_range(2));
			end
			send_pixel(r, g, b, 1'($urandom_range(1)));
		end
	endtask

	task automatic test_idling();
		send_idle_pct = 53; recv_stall_pct = 0;  test_random(200);
		send_idle_pct = 0;  recv_stall_pct = 53; test_random(200);
		send_idle_pct = 36; recv_stall_pct = 36; test_random(200);
		send_idle_pct = 0;  recv_stall_pct = 0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corners();
		test_random(230);
		test_idling();
		s_tvalid <= 1'b0;
		while (hsv_expected.size() != 0) @(posedge clk);
		repeat (SAT_FRAC_BITS + 10) @(posedge clk);
		if (mismatches == 0 && hsv_expected.size() == 0)
			$display("tb_rgb_to_hsv_pixel: PASS");
		else
			$display("tb_rgb_to_hsv_pixel: FAIL");
		$finish;
	end

	// timeout
	initial begin
		#2ms;
		$display("tb_rgb_to_hsv_pixel: FAIL");
		$finish;
	end
endmodule

[files.f]
src/rgbhsv_pkg.sv
src/rgbhsv_front.sv
src/rgbhsv_div_cell.sv
src/rgb_to_hsv_pixel.sv
verif/tb_rgb_to_hsv_pixel.sv
